### rtl/mpure_pkg.sv
// Package for the protection-region register encoder: constants, error codes,
// the fit-search result type and the permission and cache field tables.
// No dependencies.
package mpure_pkg;

  localparam int unsigned MinBlockLog = 5;
  localparam int unsigned MaxBlockLog = 22;
  localparam int unsigned NumBlocks   = MaxBlockLog - MinBlockLog + 1;
  localparam int unsigned SubShift    = 3;
  localparam int unsigned EndWidth    = MaxBlockLog + 2;
  localparam int unsigned MaxAccess   = 5;
  localparam logic [31:0] ValidBit    = 32'h0000_0010;

  typedef enum logic [2:0] {
    ErrNone          = 3'd0,
    ErrBaseMisalign  = 3'd1,
    ErrSizeUnder32   = 3'd2,
    ErrNoFit         = 3'd3,
    ErrBadAccess     = 3'd4
  } err_e;

  // Result of testing every candidate block size in parallel.
  typedef struct packed {
    logic [NumBlocks-1:0]       fit;
    logic [NumBlocks-1:0][3:0]  end_eighth;
  } fit_t;

  function automatic logic [3:0] ap_code(input logic [2:0] acc);
    logic [3:0] ap;
    case (acc)
      3'd0:    ap = 4'h0;
      3'd1:    ap = 4'h1;
      3'd2:    ap = 4'h2;
      3'd3:    ap = 4'h3;
      3'd4:    ap = 4'h5;
      3'd5:    ap = 4'h6;
      default: ap = 4'h0;
    endcase
    return ap;
  endfunction

  // TEX/S/C/B field, bits 21..16 of the attribute word.
  function automatic logic [5:0] cache_bits(input logic [1:0] mode);
    logic [5:0] bits;
    case (mode)
      2'd0:    bits = 6'h0C;
      2'd1:    bits = 6'h06;
      2'd2:    bits = 6'h0F;
      2'd3:    bits = 6'h07;
      default: bits = 6'h00;
    endcase
    return bits;
  endfunction

endpackage

### rtl/mpure_if.sv
// Valid/ready channel interfaces for requests and register-word results.
// Depends on nothing but the field widths.
interface mpure_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] region_base;
  logic [31:0] region_size;
  logic [3:0]  region_index;
  logic [2:0]  access_class;
  logic [1:0]  cache_mode;
  logic        exec_allowed;
  logic        region_on;

  modport source (
    output valid, region_base, region_size, region_index, access_class,
           cache_mode, exec_allowed, region_on,
    input  ready
  );
  modport sink (
    input  valid, region_base, region_size, region_index, access_class,
           cache_mode, exec_allowed, region_on,
    output ready
  );
endinterface

interface mpure_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] base_word;
  logic [31:0] attr_word;
  logic [2:0]  error_code;

  modport source (
    output valid, base_word, attr_word, error_code,
    input  ready
  );
  modport sink (
    input  valid, base_word, attr_word, error_code,
    output ready
  );
endinterface

### rtl/mpure_fit_check.sv
// Tests all candidate block sizes, 32 B to 4 MiB, against one base/size pair.
// Depends on mpure_pkg.
module mpure_fit_check import mpure_pkg::*; (
  input  logic [31:0] base_i,
  input  logic [31:0] size_i,
  output fit_t        fit_o
);

  for (genvar j = 0; j < NumBlocks; j++) begin : g_blk
    localparam int unsigned K = MinBlockLog + j;

    logic                size_le;
    logic                aligned;
    logic [EndWidth-1:0] start_off;
    logic [EndWidth-1:0] end_off;
    logic                end_ok;

    // The range must fit in the block, and since the start sits on an
    // eighth boundary, the end does so exactly when the size does.
    assign size_le   = {1'b0, size_i} <= (33'd1 << K);
    assign aligned   = (base_i[K-SubShift-1:0] == '0) && (size_i[K-SubShift-1:0] == '0);
    assign start_off = EndWidth'(base_i[K-1:0]);
    assign end_off   = start_off + {1'b0, size_i[EndWidth-2:0]};
    assign end_ok    = end_off <= (EndWidth'(1) << K);

    assign fit_o.fit[j]        = size_le && aligned && end_ok;
    assign fit_o.end_eighth[j] = end_off[K:K-SubShift];
  end

endmodule

### rtl/mpu_region_register_encoder_unit.sv
// Top level of the protection-region register encoder: three-stage pipeline
// from request to base/attribute register words. Depends on mpure_pkg,
// mpure_if and mpure_fit_check.
//
//   Port    Role      Transfer carries
//   req_i   sink      region_base, region_size, region_index, access_class,
//                     cache_mode, exec_allowed, region_on
//   rsp_o   source    base_word, attr_word, error_code
//
// A request passes through three register stages on its way to rsp_o; one request
// can enter every cycle while rsp_o is not stalled. The three register stages are
// the parallel block-size test, the smallest-block selection and the word assembly.
// Each stage holds while the stage after it is full and stalled; empty
// stages fill regardless. Reset empties all stages.
module mpu_region_register_encoder_unit import mpure_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  mpure_req_if.sink      req_i,
  mpure_rsp_if.source    rsp_o
);

  fit_t fit_c;

  mpure_fit_check u_fit (
    .base_i (req_i.region_base),
    .size_i (req_i.region_size),
    .fit_o  (fit_c)
  );

  logic rdy1, rdy2, rdy3;
  logic v1_q, v2_q, v3_q;

  assign rdy3        = !v3_q || rsp_o.ready;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign req_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= req_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage 1: block-size tests and the early error checks.
  logic [31:0] base1_q;
  logic [3:0]  idx1_q;
  logic [2:0]  acc1_q;
  logic [1:0]  cache1_q;
  logic        exec1_q, on1_q, misal1_q, small1_q;
  fit_t        fit1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && req_i.valid) begin
      base1_q  <= req_i.region_base;
      idx1_q   <= req_i.region_index;
      acc1_q   <= req_i.access_class;
      cache1_q <= req_i.cache_mode;
      exec1_q  <= req_i.exec_allowed;
      on1_q    <= req_i.region_on;
      misal1_q <= req_i.region_base[MinBlockLog-1:0] != '0;
      small1_q <= req_i.region_size < 32'd32;
      fit1_q   <= fit_c;
    end
  end

  // Stage 2: pick the smallest fitting block and its eighth range.
  logic [4:0]  code2_d;
  logic [2:0]  s2_d;
  logic [3:0]  e2_d;
  logic [31:0] blk2_d;
  err_e        err2_d;

  always_comb begin
    code2_d = '0;
    s2_d    = '0;
    e2_d    = '0;
    blk2_d  = '0;
    for (int j = NumBlocks - 1; j >= 0; j--) begin
      if (fit1_q.fit[j]) begin
        code2_d = 5'(MinBlockLog + j - 1);
        s2_d    = 3'(base1_q >> (MinBlockLog + j - SubShift));
        e2_d    = fit1_q.end_eighth[j];
        blk2_d  = base1_q & ~((32'd1 << (MinBlockLog + j)) - 32'd1);
      end
    end
    if (misal1_q)                     err2_d = ErrBaseMisalign;
    else if (small1_q)                err2_d = ErrSizeUnder32;
    else if (fit1_q.fit == '0)        err2_d = ErrNoFit;
    else if (acc1_q > 3'(MaxAccess))  err2_d = ErrBadAccess;
    else                              err2_d = ErrNone;
  end

  logic [4:0]  code2_q;
  logic [2:0]  s2_q;
  logic [3:0]  e2_q;
  logic [31:0] blk2_q;
  err_e        err2_q;
  logic [3:0]  idx2_q;
  logic [2:0]  acc2_q;
  logic [1:0]  cache2_q;
  logic        exec2_q, on2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      code2_q  <= code2_d;
      s2_q     <= s2_d;
      e2_q     <= e2_d;
      blk2_q   <= blk2_d;
      err2_q   <= err2_d;
      idx2_q   <= idx1_q;
      acc2_q   <= acc1_q;
      cache2_q <= cache1_q;
      exec2_q  <= exec1_q;
      on2_q    <= on1_q;
    end
  end

  // Stage 3: subregion-disable mask and the two register words.
  logic [7:0]  mask3;
  logic [31:0] base3_d, attr3_d;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask3[i] = !((4'(i) >= {1'b0, s2_q}) && (4'(i) < e2_q));
    end
    if (err2_q == ErrNone) begin
      base3_d = blk2_q | ValidBit | 32'(idx2_q);
      attr3_d = (32'(!exec2_q) << 28) | (32'(ap_code(acc2_q)) << 24)
              | (32'(cache_bits(cache2_q)) << 16) | (32'(mask3) << 8)
              | (32'(code2_q) << 1) | 32'(on2_q);
    end else begin
      base3_d = '0;
      attr3_d = '0;
    end
  end

  logic [31:0] base3_q, attr3_q;
  err_e        err3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      base3_q <= base3_d;
      attr3_q <= attr3_d;
      err3_q  <= err2_q;
    end
  end

  assign rsp_o.valid      = v3_q;
  assign rsp_o.base_word  = base3_q;
  assign rsp_o.attr_word  = attr3_q;
  assign rsp_o.error_code = err3_q;

  // A rejected request carries no register words.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && err3_q != ErrNone) |-> (base3_q == '0 && attr3_q == '0))
    else $error("error result carries nonzero register words");

  // An accepted region always sets the valid bit in the base word.
  a_ok_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && err3_q == ErrNone) |-> base3_q[4])
    else $error("valid bit missing in base word");

  // The size code stays within 32 B to 4 MiB blocks.
  a_size_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && err3_q == ErrNone) |-> (attr3_q[5:1] >= 5'd4 && attr3_q[5:1] <= 5'd21))
    else $error("size code out of range");

  // A nonempty range leaves at least one subregion enabled.
  a_mask_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && err3_q == ErrNone) |-> (attr3_q[15:8] != 8'hFF))
    else $error("all subregions disabled for an accepted region");

endmodule

### dv/tb_mpu_region_register_encoder_unit.sv
// Testbench for mpu_region_register_encoder_unit: drives protection-region requests
// and checks every base and attribute word against an in-bench encoder.
// Depends on mpure_pkg, the mpure_if channel interfaces and the RTL top level.
module tb_mpu_region_register_encoder_unit import mpure_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] base;
    logic [31:0] size;
    logic [3:0]  index;
    logic [2:0]  acc;
    logic [1:0]  cache;
    logic        exec;
    logic        on;
  } region_req_t;

  typedef struct {
    logic [31:0] base_word;
    logic [31:0] attr_word;
    err_e        err;
  } region_words_t;

  class region_word_scoreboard;
    region_words_t pending_words[$];
    int unsigned   mismatches;

    function automatic region_words_t encode_region(region_req_t r);
      region_words_t w;
      logic [63:0]   blk;
      logic [63:0]   sub;
      logic [63:0]   start;
      logic [63:0]   stop;
      logic [7:0]    disable_mask;
      logic [31:0]   blk_base;
      logic [4:0]    size_code;
      logic [3:0]    ap;
      logic [5:0]    texscb;
      int unsigned   fit_log;
      bit            found;
      w.base_word  = '0;
      w.attr_word  = '0;
      w.err        = ErrNone;
      found        = 1'b0;
      disable_mask = 8'hFF;
      blk_base     = '0;
      fit_log      = 0;
      if (r.base[4:0] != 5'd0) begin
        w.err = ErrBaseMisalign;
      end else if (r.size < 32'd32) begin
        w.err = ErrSizeUnder32;
      end else begin
        // Smallest block first; both range ends must sit on eighth-of-block boundaries.
        for (int k = MinBlockLog; k <= MaxBlockLog; k++) begin
          if (!found) begin
            blk = 64'd1 << k;
            sub = blk >> SubShift;
            if (blk >= {32'd0, r.size}) begin
              start = {32'd0, r.base} & (blk - 64'd1);
              stop  = start + {32'd0, r.size};
              if ((start & (sub - 64'd1)) == 64'd0 && (stop & (sub - 64'd1)) == 64'd0 &&
                  stop <= blk) begin
                for (int i = 0; i < 8; i++) begin
                  if (64'(i) >= (start >> (k - SubShift)) && 64'(i) < (stop >> (k - SubShift)))
                    disable_mask[i] = 1'b0;
                end
                blk_base = r.base - start[31:0];
                fit_log  = k;
                found    = 1'b1;
              end
            end
          end
        end
        if (!found) w.err = ErrNoFit;
        else if (r.acc > 3'd5) w.err = ErrBadAccess;
      end
      if (w.err == ErrNone) begin
        case (r.acc)
          3'd1:    ap = 4'h1;
          3'd2:    ap = 4'h2;
          3'd3:    ap = 4'h3;
          3'd4:    ap = 4'h5;
          3'd5:    ap = 4'h6;
          default: ap = 4'h0;
        endcase
        case (r.cache)
          2'd0:    texscb = 6'h0C;
          2'd1:    texscb = 6'h06;
          2'd2:    texscb = 6'h0F;
          default: texscb = 6'h07;
        endcase
        size_code   = 5'(fit_log - 1);
        w.base_word = blk_base | 32'h0000_0010 | {28'd0, r.index};
        // XN at 28, AP at 27..24, TEX/S/C/B at 21..16, mask at 15..8, size at 5..1.
        w.attr_word = {3'b000, ~r.exec, ap, 2'b00, texscb, disable_mask, 2'b00, size_code,
                       r.on};
      end
      return w;
    endfunction

    function void note_request(region_req_t r);
      pending_words.push_back(encode_region(r));
    endfunction

    function void check_response(logic [31:0] base_word, logic [31:0] attr_word,
                                 logic [2:0] error_code);
      region_words_t want;
      if (pending_words.size() == 0) begin
        $error("unexpected transfer: base_word %h attr_word %h error_code %0d",
               base_word, attr_word, error_code);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      if (base_word !== want.base_word) begin
        $error("base_word: expected %h, actual %h", want.base_word, base_word);
        mismatches++;
      end
      if (attr_word !== want.attr_word) begin
        $error("attr_word: expected %h, actual %h", want.attr_word, attr_word);
        mismatches++;
      end
      if (error_code !== want.err) begin
        $error("error_code: expected %0d, actual %0d", want.err, error_code);
        mismatches++;
      end
    endfunction
  endclass

  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned ItemsPerPhase = 475;
  localparam int unsigned HoldOffLen = 300;

  logic clk;
  logic rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off_reqs;
  int unsigned stuck_cycles;
  region_word_scoreboard sb;

  mpure_req_if req_ch ();
  mpure_rsp_if rsp_ch ();

  mpu_region_register_encoder_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (req_ch.valid && req_ch.ready) begin
      sb.note_request('{req_ch.region_base, req_ch.region_size, req_ch.region_index,
                        req_ch.access_class, req_ch.cache_mode, req_ch.exec_allowed,
                        req_ch.region_on});
    end
    if (rsp_ch.valid && rsp_ch.ready) begin
      sb.check_response(rsp_ch.base_word, rsp_ch.attr_word, rsp_ch.error_code);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("FAIL mpu_region_register_encoder_unit");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, or a long hold-off when one is requested.
  initial begin
    int unsigned hold_off_seen;
    hold_off_seen = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_reqs != hold_off_seen) begin
        hold_off_seen = hold_off_reqs;
        rsp_ch.ready <= 1'b0;
        repeat (HoldOffLen) @(posedge clk);
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_request(input region_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.region_base  <= r.base;
    req_ch.region_size  <= r.size;
    req_ch.region_index <= r.index;
    req_ch.access_class <= r.acc;
    req_ch.cache_mode   <= r.cache;
    req_ch.exec_allowed <= r.exec;
    req_ch.region_on    <= r.on;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Stops offering requests until every outstanding result has come back.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic region_req_t mk(logic [31:0] base, logic [31:0] size, logic [3:0] index,
                                     logic [2:0] acc, logic [1:0] cache, logic exec,
                                     logic on);
    region_req_t r;
    r = '{base, size, index, acc, cache, exec, on};
    return r;
  endfunction

  function automatic region_req_t random_request();
    region_req_t r;
    int unsigned pick;
    int unsigned k;
    int unsigned lo;
    int unsigned hi;
    logic [31:0] blk_size;
    logic [31:0] sub_size;
    r.index = 4'($urandom);
    pick    = $urandom_range(0, 99);
    r.acc   = (pick < 90) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
    r.cache = 2'($urandom);
    r.exec  = 1'($urandom);
    r.on    = 1'($urandom);
    pick    = $urandom_range(0, 99);
    if (pick < 75) begin
      // Well-formed: a run of whole subregions inside one aligned block.
      k        = $urandom_range(MinBlockLog, MaxBlockLog);
      blk_size = 32'd1 << k;
      sub_size = blk_size >> SubShift;
      lo       = $urandom_range(0, 7);
      hi       = $urandom_range(lo + 1, 8);
      r.base   = ($urandom & ~(blk_size - 32'd1)) + lo * sub_size;
      r.size   = (hi - lo) * sub_size;
    end else if (pick < 85) begin
      r.base = $urandom & ~32'h1F;
      r.size = $urandom_range(0, 32'h0080_0000);
    end else if (pick < 92) begin
      r.base = $urandom & ~32'h1F;
      r.size = $urandom;
    end else begin
      r.base = $urandom;
      r.size = $urandom_range(0, 4096);
    end
    return r;
  endfunction

  initial begin
    region_req_t directed[$];
    int unsigned send_pcts[4];
    int unsigned recv_pcts[4];
    sb = new;
    send_pcts = '{0, 47, 0, 24};
    recv_pcts = '{0, 0, 47, 24};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_reqs = 0;
    rst_n = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.region_base  = '0;
    req_ch.region_size  = '0;
    req_ch.region_index = '0;
    req_ch.access_class = '0;
    req_ch.cache_mode   = '0;
    req_ch.exec_allowed = 1'b0;
    req_ch.region_on    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk(32'h0000_0000, 32'd32, 4'd0, 3'd0, 2'd0, 1'b0, 1'b0));
    directed.push_back(mk(32'hFFFF_FFE0, 32'd32, 4'd15, 3'd5, 2'd3, 1'b1, 1'b1));
    directed.push_back(mk(32'h0000_0000, 32'h0040_0000, 4'd1, 3'd1, 2'd1, 1'b1, 1'b1));
    directed.push_back(mk(32'h00C0_0000, 32'h0040_0000, 4'd2, 3'd2, 2'd2, 1'b0, 1'b1));
    // Longer than the largest block.
    directed.push_back(mk(32'h0000_0000, 32'h0040_0020, 4'd3, 3'd3, 2'd0, 1'b1, 1'b0));
    // Ranges that run past the top of the address space.
    directed.push_back(mk(32'hFFFF_FFE0, 32'd64, 4'd4, 3'd4, 2'd1, 1'b0, 1'b1));
    directed.push_back(mk(32'hFFFF_FFE0, 32'hFFFF_FFFF, 4'd5, 3'd0, 2'd2, 1'b1, 1'b1));
    // A misaligned base wins over every other error.
    directed.push_back(mk(32'h0000_0001, 32'd0, 4'd6, 3'd1, 2'd3, 1'b0, 1'b0));
    directed.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 3'd7, 2'd3, 1'b1, 1'b1));
    directed.push_back(mk(32'h0000_0000, 32'd0, 4'd7, 3'd2, 2'd0, 1'b0, 1'b1));
    directed.push_back(mk(32'h0000_0040, 32'd31, 4'd8, 3'd6, 2'd1, 1'b1, 1'b0));
    directed.push_back(mk(32'h0000_0100, 32'h0000_0060, 4'd9, 3'd3, 2'd0, 1'b0, 1'b1));
    // Range straddling two small blocks moves up to the next size.
    directed.push_back(mk(32'h0000_0020, 32'd64, 4'd10, 3'd4, 2'd1, 1'b1, 1'b1));
    // End never lands on a subregion boundary.
    directed.push_back(mk(32'h0000_0000, 32'd33, 4'd11, 3'd5, 2'd2, 1'b0, 1'b0));
    directed.push_back(mk(32'h0000_1000, 32'h0000_0100, 4'd12, 3'd6, 2'd0, 1'b1, 1'b1));
    directed.push_back(mk(32'h0000_1000, 32'h0000_0100, 4'd13, 3'd7, 2'd3, 1'b0, 1'b1));
    // No fit is reported ahead of a bad access class.
    directed.push_back(mk(32'h0000_0020, 32'd33, 4'd14, 3'd6, 2'd2, 1'b1, 1'b0));
    directed.push_back(mk(32'h0028_0000, 32'h0018_0000, 4'd0, 3'd1, 2'd2, 1'b1, 1'b1));
    directed.push_back(mk(32'h0000_00C0, 32'h0000_0040, 4'd1, 3'd2, 2'd3, 1'b0, 1'b0));
    directed.push_back(mk(32'h0000_0080, 32'h0000_0060, 4'd8, 3'd2, 2'd2, 1'b1, 1'b0));
    foreach (directed[i]) send_request(directed[i]);
    drain_responses();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = send_pcts[phase];
      recv_idle_pct = recv_pcts[phase];
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // Result side stops for a long while so the pipeline fills and the input backs up.
        if (phase == 0 && n == 100) hold_off_reqs++;
        if (n == 250) drain_responses();
        send_request(random_request());
      end
      drain_responses();
    end

    repeat (10) @(posedge clk);
    if (sb.pending_words.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_words.size());
    end
    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("PASS mpu_region_register_encoder_unit");
    end else begin
      $display("FAIL mpu_region_register_encoder_unit");
    end
    $finish;
  end
endmodule
